### hdl/modular_inverse_ext_euclid_macros.svh
// ---------------------------------------------------------------------------
// Modular inverse assertion macros
// Concurrent assertion shorthands clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EXT_EUCLID_MACROS_SVH
`define MODULAR_INVERSE_EXT_EUCLID_MACROS_SVH

// Check cons in the same cycle as ante.
`define MIEE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define MIEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/miee_pkg.sv
// ---------------------------------------------------------------------------
// Modular inverse package
// Word types and sequencer states shared by the modular inverse block.
// ---------------------------------------------------------------------------
package miee_pkg;

  localparam int DATA_BITS = 64;

  typedef struct packed {
    logic [DATA_BITS-1:0] value;
    logic [DATA_BITS-1:0] modulus;
  } operand_word_t;

  typedef struct packed {
    logic [DATA_BITS-1:0] inverse;
    logic                 no_inverse;
  } result_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_UPDATE,
    S_FINISH
  } state_t;

endpackage

### hdl/modular_inverse_ext_euclid.sv
// ---------------------------------------------------------------------------
// Modular inverse, extended Euclidean algorithm
// Takes a value and a modulus and returns the value's inverse modulo the
// modulus, or 0 with no_inverse set when the gcd is not 1. The block works on
// one word at a time: operand_ready is high only while the sequencer is idle.
// Each Euclid round runs one shared restoring divider over WORD_BITS quotient
// bits, which it yields one bit per cycle and, in the same pass, folds the
// quotient times the current coefficient into an accumulator by shift and
// subtract. A check state opens each round and an update state closes it; a
// zero value goes straight from the check to the finish state. Coefficients
// wrap at WORD_BITS bits and a negative final coefficient gets the modulus
// added. Only the low WORD_BITS bits of each operand field are used; results
// are zero-extended. The result sits in an output register, so the next
// operand word is taken as soon as the sequencer goes idle, while a finished
// result may still wait.
// ---------------------------------------------------------------------------
`include "modular_inverse_ext_euclid_macros.svh"

module modular_inverse_ext_euclid
  import miee_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          operand_valid,
  output logic          operand_ready,
  input  operand_word_t operand,
  output logic          result_valid,
  input  logic          result_ready,
  output result_word_t  result
);

  localparam int CNT_BITS = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  state_t state, state_next;

  // Euclid state: remainders and wrapped two's complement coefficients.
  logic [WORD_BITS-1:0] prev_r, cur_r;
  logic [WORD_BITS-1:0] prev_t, cur_t;
  logic [WORD_BITS-1:0] modulus;

  // Shared divider: partial remainder, dividend shifter, running -q*cur_t.
  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] dvd;
  logic [WORD_BITS-1:0] acc;
  logic [CNT_BITS-1:0]  cnt;

  logic                 operand_fire;
  logic                 result_load;
  logic [WORD_BITS:0]   trial;
  logic                 trial_ge;
  logic [WORD_BITS-1:0] fixed_t;

  assign operand_ready = (state == S_IDLE);
  assign operand_fire  = operand_valid && operand_ready;
  // Load a result only once the output register is free or being emptied.
  assign result_load   = (state == S_FINISH) && (!result_valid || result_ready);

  // Divider step: shift in the next dividend bit, subtract when it fits.
  assign trial    = {rem, dvd[WORD_BITS-1]};
  assign trial_ge = (trial >= {1'b0, cur_r});

  // Bring a negative coefficient into range.
  assign fixed_t  = prev_t[WORD_BITS-1] ? (prev_t + modulus) : prev_t;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (operand_fire) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        // Stop once the remainder reaches zero; prev_r then holds the gcd.
        state_next = (cur_r == '0) ? S_FINISH : S_DIV;
      end
      S_DIV: begin
        if (cnt == '0) begin
          state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        state_next = S_CHECK;
      end
      S_FINISH: begin
        if (result_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath registers; they carry no reset.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (operand_fire) begin
          modulus <= WORD_BITS'(operand.modulus);
          prev_r  <= WORD_BITS'(operand.modulus);
          cur_r   <= WORD_BITS'(operand.value);
          prev_t  <= '0;
          cur_t   <= WORD_BITS'(1);
        end
      end
      S_CHECK: begin
        rem <= '0;
        dvd <= prev_r;
        acc <= '0;
        cnt <= CNT_BITS'(WORD_BITS - 1);
      end
      S_DIV: begin
        rem <= trial_ge ? WORD_BITS'(trial - {1'b0, cur_r}) : trial[WORD_BITS-1:0];
        dvd <= {dvd[WORD_BITS-2:0], 1'b0};
        // Horner form of -q*cur_t, quotient bits arriving MSB first.
        acc <= {acc[WORD_BITS-2:0], 1'b0} - (trial_ge ? cur_t : '0);
        cnt <= cnt - CNT_BITS'(1);
      end
      S_UPDATE: begin
        prev_r <= cur_r;
        cur_r  <= rem;
        prev_t <= cur_t;
        cur_t  <= prev_t + acc;
      end
      default: begin
      end
    endcase
  end

  // Output register: hold the word until taken, drop valid after the take.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      if (prev_r != WORD_BITS'(1)) begin
        result.inverse    <= '0;
        result.no_inverse <= 1'b1;
      end else begin
        result.inverse    <= DATA_BITS'(fixed_t);
        result.no_inverse <= 1'b0;
      end
    end
  end

  // Checks on the sequencer and the divider.
  `MIEE_ASSERT_NEXT(a_accept_starts, operand_fire, state == S_CHECK,
                    "accepted word did not start a round check")
  `MIEE_ASSERT_NEXT(a_div_ends, (state == S_DIV) && (cnt == '0), state == S_UPDATE,
                    "divider pass did not end in the update step")
  `MIEE_ASSERT_SAME(a_rem_bound, state == S_DIV, rem < cur_r,
                    "partial remainder not below divisor")
  `MIEE_ASSERT_SAME(a_no_inv_zero, result_valid && result.no_inverse,
                    result.inverse == '0, "no-inverse result carries nonzero inverse")

endmodule
